FILE: hdl/csvs_pkg.sv
// Shared types and constants for the CSV field splitter.
// Holds the parse mode encoding, result and run structures, and byte codes.
// No dependencies.
`default_nettype none

package csvs_pkg;

  localparam logic [7:0] QUOTE_BYTE = 8'd34;
  localparam logic [7:0] SPACE_BYTE = 8'd32;
  localparam logic [7:0] LF_BYTE    = 8'd10;
  localparam logic [7:0] FF_BYTE    = 8'd12;
  localparam logic [7:0] CR_BYTE    = 8'd13;

  localparam logic [7:0] DELIM_RESET = 8'd44;
  localparam logic [7:0] FILL_RESET  = 8'd48;

  localparam int unsigned RUN_MAX = 4;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned IDX_W   = 2;

  typedef enum logic [0:0] {
    REG_DELIMITER  = 1'b0,
    REG_EMPTY_FILL = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    MODE_START  = 4'b0001,
    MODE_PLAIN  = 4'b0010,
    MODE_QUOTED = 4'b0100,
    MODE_QSEEN  = 4'b1000
  } parse_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       field_end;
    logic       record_end;
  } res_t;

  typedef struct packed {
    res_t [RUN_MAX-1:0] ent;
    logic [CNT_W-1:0]   cnt;
  } run_t;

  function automatic res_t mk_byte(input logic [7:0] b);
    res_t r;
    r.data       = b;
    r.field_end  = 1'b0;
    r.record_end = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_end(input logic rec);
    res_t r;
    r.data       = 8'd0;
    r.field_end  = 1'b1;
    r.record_end = rec;
    return r;
  endfunction

  function automatic logic is_break(input logic [7:0] c);
    return (c == LF_BYTE) || (c == FF_BYTE) || (c == CR_BYTE);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/csvs_decode.sv
// Parser state and per-byte decode for the CSV field splitter.
// Turns one registered text byte into a run of up to four results.
// Depends on csvs_pkg.
`default_nettype none

module csvs_decode
  import csvs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       advance,
  input  wire logic [7:0] ch,
  input  wire logic       final_byte,
  input  wire logic [7:0] delimiter,
  input  wire logic [7:0] empty_fill,
  output run_t            run
);

  parse_mode_t mode, mode_next;
  logic        after_delim, after_delim_next;

  always_comb begin
    parse_mode_t      mode_m;
    logic             ad_m;
    logic [1:0]       n1;
    logic [1:0]       n2;
    res_t             a0, a1, b0, b1;
    logic             is_d, is_b, is_q;

    is_d   = (ch == delimiter);
    is_b   = is_break(ch);
    is_q   = (ch == QUOTE_BYTE);
    mode_m = mode;
    ad_m   = after_delim;
    n1     = 2'd0;
    n2     = 2'd0;
    a0     = mk_byte(empty_fill);
    a1     = mk_end(1'b0);
    b0     = mk_byte(empty_fill);
    b1     = mk_end(1'b1);

    unique case (mode)
      MODE_START: begin
        if (is_d) begin
          n1   = 2'd2;
          ad_m = 1'b1;
        end else if (is_b) begin
          // A break at a record start (blank line, LF of CR LF) emits nothing.
          if (after_delim) begin
            n1 = 2'd2;
            a1 = mk_end(1'b1);
          end
          ad_m = 1'b0;
        end else if (is_q) begin
          mode_m = MODE_QUOTED;
          ad_m   = 1'b1;
        end else begin
          n1     = 2'd1;
          a0     = mk_byte(ch);
          mode_m = MODE_PLAIN;
          ad_m   = 1'b0;
        end
      end
      MODE_PLAIN: begin
        if (is_d) begin
          n1     = 2'd1;
          a0     = mk_end(1'b0);
          mode_m = MODE_START;
          ad_m   = 1'b1;
        end else if (is_b) begin
          n1     = 2'd1;
          a0     = mk_end(1'b1);
          mode_m = MODE_START;
          ad_m   = 1'b0;
        end else if (!is_q) begin
          n1 = 2'd1;
          a0 = mk_byte(ch);
        end
      end
      MODE_QUOTED: begin
        if (is_q) begin
          mode_m = MODE_QSEEN;
        end else begin
          n1   = 2'd1;
          a0   = mk_byte(is_b ? SPACE_BYTE : ch);
          ad_m = 1'b0;
        end
      end
      MODE_QSEEN: begin
        if (is_q) begin
          n1     = 2'd1;
          a0     = mk_byte(QUOTE_BYTE);
          mode_m = MODE_QUOTED;
          ad_m   = 1'b0;
        end else if (is_d || is_b) begin
          // Close the quoted field, with the fill byte when it stayed empty.
          // The delimiter takes precedence, so only a plain break ends the record.
          if (after_delim) begin
            n1 = 2'd2;
            a1 = mk_end(!is_d);
          end else begin
            n1 = 2'd1;
            a0 = mk_end(!is_d);
          end
          mode_m = MODE_START;
          ad_m   = is_d;
        end else begin
          n1     = 2'd1;
          a0     = mk_byte(ch);
          mode_m = MODE_PLAIN;
          ad_m   = 1'b0;
        end
      end
      default: begin
        mode_m = MODE_START;
        ad_m   = 1'b0;
      end
    endcase

    mode_next        = mode_m;
    after_delim_next = ad_m;

    if (final_byte) begin
      unique case (mode_m)
        MODE_START: begin
          if (ad_m) begin
            n2 = 2'd2;
          end
        end
        MODE_PLAIN: begin
          n2 = 2'd1;
          b0 = mk_end(1'b1);
        end
        default: begin
          if (ad_m) begin
            n2 = 2'd2;
          end else begin
            n2 = 2'd1;
            b0 = mk_end(1'b1);
          end
        end
      endcase
      mode_next        = MODE_START;
      after_delim_next = 1'b0;
    end

    run.ent = '0;
    unique case (n1)
      2'd0: begin
        run.ent[0] = b0;
        run.ent[1] = b1;
      end
      2'd1: begin
        run.ent[0] = a0;
        run.ent[1] = b0;
        run.ent[2] = b1;
      end
      default: begin
        run.ent[0] = a0;
        run.ent[1] = a1;
        run.ent[2] = b0;
        run.ent[3] = b1;
      end
    endcase
    run.cnt = CNT_W'(n1) + CNT_W'(n2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_START;
      after_delim <= 1'b0;
    end else if (advance) begin
      mode        <= mode_next;
      after_delim <= after_delim_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/csvs_run_buf.sv
// Result register for the CSV field splitter.
// Holds one decoded run and hands its results out one per transaction.
// Depends on csvs_pkg.
`default_nettype none

module csvs_run_buf
  import csvs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  run_t            run_in,
  output logic            take,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,
  output logic [1:0]      m_tuser,
  output logic            m_tlast
);

  res_t [RUN_MAX-1:0] ent;
  logic [CNT_W-1:0]   cnt;
  logic [IDX_W-1:0]   idx;
  res_t               cur;

  assign cur      = ent[idx];
  assign m_tvalid = (cnt != '0);
  assign m_tdata  = cur.data;
  assign m_tuser  = {cur.record_end, cur.field_end};
  assign m_tlast  = (cnt == CNT_W'(1));

  // A new run may enter when the register is empty or its last result leaves now.
  assign take = (cnt == '0) || (m_tlast && m_tready);

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= run_in.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load) begin
      cnt <= run_in.cnt;
      idx <= '0;
    end else if (m_tvalid && m_tready) begin
      cnt <= cnt - CNT_W'(1);
      idx <= idx + IDX_W'(1);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/csv_field_splitter_unit.sv
// CSV field splitter: one text byte in, up to four field results out.
// An accepted byte is held in the input byte register, then its decoded run goes into the result register.
// Throughput: one byte per cycle while each byte gives at most one result and m_tready is high;
// a byte that gives n results holds the result register until all n of them have left.
// Reset (rst, synchronous): delimiter ',' and fill '0', parser at record start.
`default_nettype none

module csv_field_splitter_unit
  import csvs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] ch
  input  wire logic       s_tlast,   // final_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic [1:0]      m_tuser,   // [0] field_end, [1] record_end
  output logic            m_tlast,   // last_of_run
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic [7:0] delimiter;
  logic [7:0] empty_fill;
  logic       in_valid;
  logic [7:0] in_ch;
  logic       in_final;
  logic       take;
  logic       advance;
  run_t       run;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter  <= DELIM_RESET;
      empty_fill <= FILL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DELIMITER:  delimiter  <= cfg_data;
        REG_EMPTY_FILL: empty_fill <= cfg_data;
        default:        delimiter  <= delimiter;
      endcase
    end
  end

  assign advance  = in_valid && take;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ch    <= s_tdata;
      in_final <= s_tlast;
    end
  end

  csvs_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .ch         (in_ch),
    .final_byte (in_final),
    .delimiter  (delimiter),
    .empty_fill (empty_fill),
    .run        (run)
  );

  csvs_run_buf u_run_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .run_in   (run),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for csv_field_splitter_unit: a directed table of CSV bytes,
// then generated records under several delimiter and fill settings, all checked token by token.
// Depends on csvs_pkg and csv_field_splitter_unit only.
module tb_top
  import csvs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD  = 60;
  localparam int SETTLE     = 8;
  localparam int PHASE_ITEMS = 14;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       field_end;
    logic       record_end;
    logic       last_of_run;
  } tok_t;

  typedef struct packed {
    logic [7:0]   ch;
    logic         fin;
    logic         typed;
    logic [2:0]   n;
    tok_t [3:0]   toks;
  } dir_row_t;

  localparam tok_t NOTOK = '0;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [0:0] cfg_index = REG_DELIMITER;
  logic [7:0] cfg_data = 8'd0;

  csv_field_splitter_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Tokenizer shadow state and register copies.
  parse_mode_t mode_sh;
  logic        pending_sh;
  logic [7:0]  delim_sh;
  logic [7:0]  fill_sh;

  tok_t       run_q[$];
  tok_t       expected_tokens[$];
  logic [7:0] text_q[$];
  dir_row_t   dir_rows[$];

  int  errors = 0;
  int  items_sent = 0;
  int  tokens_checked = 0;
  int  settings_used = 1;
  bit  hold_req = 1'b0;
  bit  quiet = 1'b0;

  function automatic tok_t tk(input logic [7:0] b, input logic fe, input logic re,
                              input logic lst);
    tok_t t;
    t.out_byte    = b;
    t.field_end   = fe;
    t.record_end  = re;
    t.last_of_run = lst;
    return t;
  endfunction

  task automatic add_content(input logic [7:0] b);
    run_q.push_back(tk(b, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic add_close(input logic empty, input logic rec);
    if (empty) add_content(fill_sh);
    run_q.push_back(tk(8'd0, 1'b1, rec, 1'b0));
  endtask

  // Computes the tokens one text byte gives and advances the shadow parser.
  task automatic tokenize_byte(input logic [7:0] c, input logic fin);
    logic brk;
    tok_t t;
    run_q.delete();
    brk = (c == LF_BYTE) || (c == FF_BYTE) || (c == CR_BYTE);
    case (mode_sh)
      MODE_START: begin
        if (c == delim_sh) begin
          add_close(1'b1, 1'b0);
          pending_sh = 1'b1;
        end else if (brk) begin
          if (pending_sh) add_close(1'b1, 1'b1);
          pending_sh = 1'b0;
        end else if (c == QUOTE_BYTE) begin
          mode_sh = MODE_QUOTED;
          pending_sh = 1'b1;
        end else begin
          add_content(c);
          mode_sh = MODE_PLAIN;
          pending_sh = 1'b0;
        end
      end
      MODE_PLAIN: begin
        if (c == delim_sh) begin
          add_close(1'b0, 1'b0);
          mode_sh = MODE_START;
          pending_sh = 1'b1;
        end else if (brk) begin
          add_close(1'b0, 1'b1);
          mode_sh = MODE_START;
          pending_sh = 1'b0;
        end else if (c != QUOTE_BYTE) begin
          add_content(c);
        end
      end
      MODE_QUOTED: begin
        if (c == QUOTE_BYTE) begin
          mode_sh = MODE_QSEEN;
        end else begin
          add_content(brk ? SPACE_BYTE : c);
          pending_sh = 1'b0;
        end
      end
      default: begin
        // A quote has been seen inside a quoted field.
        if (c == QUOTE_BYTE) begin
          add_content(QUOTE_BYTE);
          mode_sh = MODE_QUOTED;
          pending_sh = 1'b0;
        end else if (c == delim_sh) begin
          add_close(pending_sh, 1'b0);
          mode_sh = MODE_START;
          pending_sh = 1'b1;
        end else if (brk) begin
          add_close(pending_sh, 1'b1);
          mode_sh = MODE_START;
          pending_sh = 1'b0;
        end else begin
          add_content(c);
          mode_sh = MODE_PLAIN;
          pending_sh = 1'b0;
        end
      end
    endcase
    if (fin) begin
      if (mode_sh == MODE_START) begin
        if (pending_sh) add_close(1'b1, 1'b1);
      end else if (mode_sh == MODE_PLAIN) begin
        add_close(1'b0, 1'b1);
      end else begin
        add_close(pending_sh, 1'b1);
      end
      mode_sh = MODE_START;
      pending_sh = 1'b0;
    end
    if (run_q.size() > 0) begin
      t = run_q.pop_back();
      t.last_of_run = 1'b1;
      run_q.push_back(t);
    end
  endtask

  task automatic report_mismatch(input string what, input tok_t got, input tok_t want);
    errors++;
    if (errors <= 20)
      $display("ERROR %0t %s: got %02h/%0b/%0b/%0b want %02h/%0b/%0b/%0b", $time, what,
               got.out_byte, got.field_end, got.record_end, got.last_of_run,
               want.out_byte, want.field_end, want.record_end, want.last_of_run);
  endtask

  always @(posedge clk) begin : token_monitor
    tok_t got;
    tok_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = tk(m_tdata, m_tuser[0], m_tuser[1], m_tlast);
      if (expected_tokens.size() == 0) begin
        report_mismatch("unexpected token", got, NOTOK);
      end else begin
        want = expected_tokens.pop_front();
        tokens_checked++;
        if (got.out_byte !== want.out_byte) report_mismatch("out_byte", got, want);
        if (got.field_end !== want.field_end) report_mismatch("field_end", got, want);
        if (got.record_end !== want.record_end) report_mismatch("record_end", got, want);
        if (got.last_of_run !== want.last_of_run) report_mismatch("last_of_run", got, want);
      end
    end
  end

  // Result side: random stalls, one long hold-off on request, none once quiet.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Offers one byte, waits for the transaction, then queues what it should give.
  task automatic push_item(input logic [7:0] ch, input logic fin, input logic typed,
                           input logic [2:0] n, input tok_t [3:0] toks);
    s_tdata  <= ch;
    s_tlast  <= fin;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    tokenize_byte(ch, fin);
    if (typed) begin
      for (int i = 0; i < n; i++) expected_tokens.push_back(toks[i]);
    end else begin
      foreach (run_q[i]) expected_tokens.push_back(run_q[i]);
    end
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] d, input logic [7:0] f);
    drain();
    for (int r = 0; r < 2; r++) begin
      cfg_index <= (r == 0) ? REG_DELIMITER : REG_EMPTY_FILL;
      cfg_data  <= (r == 0) ? d : f;
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    delim_sh = d;
    fill_sh  = f;
    settings_used++;
  endtask

  task automatic add_row(input logic [7:0] ch, input logic fin);
    dir_row_t r;
    r = '0;
    r.ch  = ch;
    r.fin = fin;
    dir_rows.push_back(r);
  endtask

  task automatic add_typed(input logic [7:0] ch, input logic fin, input logic [2:0] n,
                           input tok_t t0, input tok_t t1, input tok_t t2, input tok_t t3);
    dir_row_t r;
    r.ch      = ch;
    r.fin     = fin;
    r.typed   = 1'b1;
    r.n       = n;
    r.toks[0] = t0;
    r.toks[1] = t1;
    r.toks[2] = t2;
    r.toks[3] = t3;
    dir_rows.push_back(r);
  endtask

  function automatic logic [7:0] text_byte();
    return 8'($urandom_range(8'h21, 8'h7e));
  endfunction

  function automatic logic [7:0] break_byte();
    case ($urandom_range(0, 2))
      0:       return LF_BYTE;
      1:       return FF_BYTE;
      default: return CR_BYTE;
    endcase
  endfunction

  // Appends one mostly well-formed record, or a short burst of raw noise.
  task automatic build_record();
    int nf;
    int kind;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      nf = $urandom_range(1, 4);
      for (int i = 0; i < nf; i++) begin
        if (i > 0) text_q.push_back(delim_sh);
        kind = $urandom_range(0, 9);
        if (kind >= 2 && kind < 6) begin
          repeat ($urandom_range(1, 4)) text_q.push_back(text_byte());
          if ($urandom_range(0, 7) == 0) text_q.push_back(QUOTE_BYTE);
        end else if (kind >= 6 && kind < 9) begin
          text_q.push_back(QUOTE_BYTE);
          repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 5))
              0: text_q.push_back(delim_sh);
              1: text_q.push_back(break_byte());
              2: begin
                text_q.push_back(QUOTE_BYTE);
                text_q.push_back(QUOTE_BYTE);
              end
              default: text_q.push_back(text_byte());
            endcase
          end
          text_q.push_back(QUOTE_BYTE);
          if ($urandom_range(0, 5) == 0) text_q.push_back(text_byte());
        end else if (kind == 9) begin
          text_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      case ($urandom_range(0, 3))
        0: begin
          text_q.push_back(CR_BYTE);
          text_q.push_back(LF_BYTE);
        end
        1: text_q.push_back(LF_BYTE);
        2: begin
          text_q.push_back(delim_sh);
          text_q.push_back(LF_BYTE);
        end
        default: text_q.push_back(CR_BYTE);
      endcase
    end
  endtask

  task automatic random_phase(input int n, input int pause_at);
    logic [7:0] c;
    logic       fin;
    for (int k = 0; k < n; k++) begin
      if (k == pause_at) drain();
      if (text_q.size() == 0) build_record();
      c   = text_q.pop_front();
      fin = (k == n - 1) || ($urandom_range(0, 24) == 0);
      push_item(c, fin, 1'b0, 3'd0, '0);
    end
  endtask

  initial begin
    #2_000_000;
    $display("csv_field_splitter_unit: mismatch");
    $finish;
  end

  initial begin
    logic [7:0] d;
    logic [7:0] f;
    mode_sh    = MODE_START;
    pending_sh = 1'b0;
    delim_sh   = DELIM_RESET;
    fill_sh    = FILL_RESET;

    add_typed("a", 1'b0, 3'd1, tk("a", 1'b0, 1'b0, 1'b1), NOTOK, NOTOK, NOTOK);
    add_typed(DELIM_RESET, 1'b0, 3'd1, tk(8'd0, 1'b1, 1'b0, 1'b1), NOTOK, NOTOK, NOTOK);
    add_typed(DELIM_RESET, 1'b0, 3'd2, tk(FILL_RESET, 1'b0, 1'b0, 1'b0),
              tk(8'd0, 1'b1, 1'b0, 1'b1), NOTOK, NOTOK);
    // Trailing delimiter before CR, then the LF of the pair gives nothing.
    add_typed(CR_BYTE, 1'b0, 3'd2, tk(FILL_RESET, 1'b0, 1'b0, 1'b0),
              tk(8'd0, 1'b1, 1'b1, 1'b1), NOTOK, NOTOK);
    add_typed(LF_BYTE, 1'b0, 3'd0, NOTOK, NOTOK, NOTOK, NOTOK);
    // Quoted field holding a delimiter, a line break and a doubled quote.
    add_row(QUOTE_BYTE, 1'b0);
    add_row(DELIM_RESET, 1'b0);
    add_row(FF_BYTE, 1'b0);
    add_row(QUOTE_BYTE, 1'b0);
    add_row(QUOTE_BYTE, 1'b0);
    add_row(QUOTE_BYTE, 1'b0);
    // Byte after the closing quote, then a stray quote in the unquoted tail.
    add_row("x", 1'b0);
    add_row(QUOTE_BYTE, 1'b0);
    add_row(8'hff, 1'b0);
    add_row(DELIM_RESET, 1'b0);
    // Empty quoted field closed by a line break.
    add_row(QUOTE_BYTE, 1'b0);
    add_row(QUOTE_BYTE, 1'b0);
    add_row(CR_BYTE, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(DELIM_RESET, 1'b0);
    // Delimiter as the last byte of the text gives two empty fields here.
    add_typed(DELIM_RESET, 1'b1, 3'd4, tk(FILL_RESET, 1'b0, 1'b0, 1'b0),
              tk(8'd0, 1'b1, 1'b0, 1'b0), tk(FILL_RESET, 1'b0, 1'b0, 1'b0),
              tk(8'd0, 1'b1, 1'b1, 1'b1));
    add_row(QUOTE_BYTE, 1'b0);
    add_row("q", 1'b1);
    add_typed(LF_BYTE, 1'b1, 3'd0, NOTOK, NOTOK, NOTOK, NOTOK);
    add_typed("z", 1'b1, 3'd2, tk("z", 1'b0, 1'b0, 1'b0), tk(8'd0, 1'b1, 1'b1, 1'b1),
              NOTOK, NOTOK);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      push_item(dir_rows[i].ch, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].n,
                dir_rows[i].toks);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin d = DELIM_RESET; f = FILL_RESET; end
        1: begin d = 8'h00; f = 8'hff; end
        2: begin d = 8'hff; f = 8'h00; end
        3: begin d = QUOTE_BYTE; f = 8'($urandom_range(0, 255)); end
        4: begin d = LF_BYTE; f = 8'($urandom_range(0, 255)); end
        default: begin d = 8'($urandom_range(0, 255)); f = 8'($urandom_range(0, 255)); end
      endcase
      if (p > 0) set_config(d, f);
      // The output side holds off while bytes keep coming, so the block backs up.
      if (p == 1) hold_req = 1'b1;
      if (p == 5) quiet = 1'b1;
      random_phase(PHASE_ITEMS, (p == 0) ? PHASE_ITEMS / 2 : -1);
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d text bytes (%0d from the directed table) under %0d register settings,",
             items_sent, dir_rows.size(), settings_used);
    $display("including quote and line-break delimiters; %0d output tokens compared.",
             tokens_checked);
    if (errors == 0) begin
      $display("csv_field_splitter_unit: match");
    end else begin
      $display("csv_field_splitter_unit: mismatch");
    end
    $finish;
  end
endmodule
